// ===== design/dq_pkg.sv =====
// Package for the double-ended queue: request and response transaction types,
// mode and status codes, and the control structs passed between its modules.
// No dependencies.
package dq_pkg;

   localparam int WORD_W = 32;
   localparam int FILL_W = 7;

   typedef enum logic [2:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_PUSH_BACK  = 3'd1,
      MODE_POP_FRONT  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_PEEK_FRONT = 3'd4,
      MODE_PEEK_BACK  = 3'd5,
      MODE_CLEAR      = 3'd6,
      MODE_NONE       = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      mode_type                  mode;
      logic signed [WORD_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [WORD_W-1:0]  read_value;
      logic [FILL_W-1:0]         fill_count;
   } rsp_type;

   // Memory access issued for one transaction.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_cmd_type;

   // Outcome of one transaction, carried until the read data returns.
   typedef struct packed {
      status_type         status;
      logic               is_read;
      logic [FILL_W-1:0]  fill_count;
   } result_type;

endpackage

// ===== design/double_ended_queue.sv =====
// Top level of the double-ended queue: pointer control, word store, and the
// read-return and response registers. Uses dq_pkg, dq_ctrl and dq_store.
//
//   channel | ports                              | direction | payload
//   --------+------------------------------------+-----------+---------------
//   request | req_valid, req_ready, req_data     | in        | dq_pkg::req_type
//   result  | rsp_valid, rsp_ready, rsp_data     | out       | dq_pkg::rsp_type
//
// One transaction per cycle while the result channel is not stalled. The word
// store is read at the accepting edge, and its registered read word is taken
// into the response register once the response slot is free.
// Reset clears the front index, the held count and both pipeline stages.
// A stalled result holds the read-return stage; requests stop only when
// both stages are full.
module double_ended_queue #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dq_pkg::req_type  req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dq_pkg::rsp_type  rsp_data
);
   import dq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic                     accept;
   mem_cmd_type              cmd;
   logic [IDX_W-1:0]         addr;
   result_type               result;
   logic signed [WORD_W-1:0] rdata;

   logic        pend_ff, pend_in;
   result_type  pend_info_ff;
   logic        pend_move;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff;

   assign pend_move = pend_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~pend_ff | pend_move;
   assign accept    = req_valid & req_ready;

   dq_ctrl #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .mode   (req_data.mode),
      .cmd    (cmd),
      .addr   (addr),
      .result (result)
   );

   dq_store #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_store (
      .clock (clock),
      .cmd   (cmd),
      .addr  (addr),
      .wdata (req_data.value),
      .rdata (rdata)
   );

   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (pend_move) begin
         pend_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (pend_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         pend_info_ff <= result;
      end
      // store data is valid the cycle after the read; zero for non-reads
      if (pend_move) begin
         rsp_ff.status     <= pend_info_ff.status;
         rsp_ff.read_value <= pend_info_ff.is_read ? rdata : '0;
         rsp_ff.fill_count <= pend_info_ff.fill_count;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/dq_store.sv =====
// Word store of the double-ended queue: one synchronous memory with a single
// address, a write port and a registered read port. Uses dq_pkg.
module dq_store #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                           clock,
   input  dq_pkg::mem_cmd_type            cmd,
   input  logic [IDX_W-1:0]               addr,
   input  logic signed [dq_pkg::WORD_W-1:0] wdata,
   output logic signed [dq_pkg::WORD_W-1:0] rdata
);
   import dq_pkg::*;

   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wdata;
      end
      // hold the last read word until the next read
      if (cmd.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/dq_ctrl.sv =====
// Pointer control of the double-ended queue: front index and held count,
// address and command for the word store, status of each transaction.
// Uses dq_pkg.
module dq_ctrl #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6,
   parameter int CNT_W = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  dq_pkg::mode_type     mode,
   output dq_pkg::mem_cmd_type  cmd,
   output logic [IDX_W-1:0]     addr,
   output dq_pkg::result_type   result
);
   import dq_pkg::*;

   localparam int SUM_W = CNT_W + 1;
   localparam int EXT_W = (CNT_W > FILL_W) ? CNT_W : FILL_W;

   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] sum;
   logic [IDX_W-1:0] tail, back, prev_front, next_front;
   logic             full, empty;
   logic             rd_en, wr_en;
   logic [EXT_W-1:0] count_ext;
   status_type       status;

   always_comb begin
      sum = SUM_W'(front_ff) + SUM_W'(count_ff);
      // front + count stays below twice the depth
      if (sum >= SUM_W'(DEPTH)) begin
         tail = IDX_W'(sum - SUM_W'(DEPTH));
      end else begin
         tail = IDX_W'(sum);
      end
      back       = (tail == '0) ? IDX_W'(DEPTH - 1) : tail - IDX_W'(1);
      prev_front = (front_ff == '0) ? IDX_W'(DEPTH - 1) : front_ff - IDX_W'(1);
      next_front = (front_ff == IDX_W'(DEPTH - 1)) ? '0 : front_ff + IDX_W'(1);
      full  = (count_ff == CNT_W'(DEPTH));
      empty = (count_ff == '0);

      front_in = front_ff;
      count_in = count_ff;
      addr     = front_ff;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      status   = STATUS_OK;

      case (mode)
         MODE_PUSH_FRONT: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               front_in = prev_front;
               count_in = count_ff + CNT_W'(1);
               addr     = prev_front;
               wr_en    = 1'b1;
            end
         end
         MODE_PUSH_BACK: begin
            if (full) begin
               status = STATUS_FULL;
            end else begin
               count_in = count_ff + CNT_W'(1);
               addr     = tail;
               wr_en    = 1'b1;
            end
         end
         MODE_POP_FRONT: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               front_in = next_front;
               count_in = count_ff - CNT_W'(1);
               rd_en    = 1'b1;
            end
         end
         MODE_POP_BACK: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               addr     = back;
               rd_en    = 1'b1;
            end
         end
         MODE_PEEK_FRONT: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               rd_en = 1'b1;
            end
         end
         MODE_PEEK_BACK: begin
            if (empty) begin
               status = STATUS_EMPTY;
            end else begin
               addr  = back;
               rd_en = 1'b1;
            end
         end
         MODE_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase

      count_ext         = EXT_W'(count_in);
      cmd.wr_en         = accept & wr_en;
      cmd.rd_en         = accept & rd_en;
      result.status     = status;
      result.is_read    = rd_en;
      result.fill_count = count_ext[FILL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== tb/double_ended_queue_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: predicts each response from the
// accepted request stream and compares it with the result channel.
// Depends on dq_pkg and the double_ended_queue RTL.
module double_ended_queue_test;
   import dq_pkg::*;

   localparam int DEPTH        = 64;
   localparam int PHASE_ITEMS  = 75;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int NUM_PHASES   = 4;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_req_q[$];
   rsp_type expected_rsp_q[$];
   int      queued_total   = 0;
   int      accepted_total = 0;
   int      counted_items  = 0;
   int      error_count    = 0;
   int      send_idle_pct  = 0;
   int      rsp_stall_pct  = 0;
   int      send_pcts[NUM_PHASES] = '{0, 72, 0, 9};
   int      rsp_pcts[NUM_PHASES]  = '{0, 0, 72, 9};

   logic    hold_trigger = 1'b0;
   logic    hold_seen    = 1'b0;
   int      hold_left    = 0;

   // Predicted queue contents
   logic signed [WORD_W-1:0] word_mem [DEPTH];
   int      front_idx  = 0;
   int      held_words = 0;

   double_ended_queue #(.DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type apply_request(input req_type r);
      rsp_type res;
      int      back_idx;
      res = '0;
      res.status = STATUS_OK;
      case (r.mode)
         MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
            if (held_words >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               if (r.mode == MODE_PUSH_FRONT) begin
                  front_idx = (front_idx + DEPTH - 1) % DEPTH;
                  word_mem[front_idx] = r.value;
               end else begin
                  word_mem[(front_idx + held_words) % DEPTH] = r.value;
               end
               held_words++;
            end
         end
         MODE_POP_FRONT, MODE_POP_BACK, MODE_PEEK_FRONT, MODE_PEEK_BACK: begin
            if (held_words == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               back_idx = (front_idx + held_words - 1) % DEPTH;
               if (r.mode == MODE_POP_FRONT || r.mode == MODE_PEEK_FRONT)
                  res.read_value = word_mem[front_idx];
               else
                  res.read_value = word_mem[back_idx];
               if (r.mode == MODE_POP_FRONT) begin
                  front_idx = (front_idx + 1) % DEPTH;
                  held_words--;
               end else if (r.mode == MODE_POP_BACK) begin
                  held_words--;
               end
            end
         end
         MODE_CLEAR: begin
            front_idx  = 0;
            held_words = 0;
         end
         default: ;
      endcase
      res.fill_count = FILL_W'(held_words);
      return res;
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(apply_request(req_data));
            accepted_total++;
         end
         if (!req_valid || req_ready) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_req_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started by toggling hold_trigger
   always @(posedge clock) begin
      if (reset) begin
         hold_seen <= 1'b0;
         hold_left <= 0;
      end else if (hold_trigger != hold_seen) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response monitor
   always @(posedge clock) begin : monitor_blk
      rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response: status %0d read_value %0d fill_count %0d",
                      rsp_data.status, rsp_data.read_value, rsp_data.fill_count);
               error_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status: expected %0d, got %0d", exp_rsp.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.read_value !== exp_rsp.read_value) begin
                  $error("read_value: expected %0d, got %0d",
                         exp_rsp.read_value, rsp_data.read_value);
                  error_count++;
               end
               if (rsp_data.fill_count !== exp_rsp.fill_count) begin
                  $error("fill_count: expected %0d, got %0d",
                         exp_rsp.fill_count, rsp_data.fill_count);
                  error_count++;
               end
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(7))
         0:       return {1'b1, {(WORD_W-1){1'b0}}};
         1:       return {1'b0, {(WORD_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_req(input mode_type m, input logic signed [WORD_W-1:0] v);
      req_type r;
      r.mode  = m;
      r.value = v;
      pending_req_q.push_back(r);
      queued_total++;
      if (m != MODE_NONE)
         counted_items++;
   endtask

   task automatic add_segment(input int kind);
      int len;
      int pick;
      len = $urandom_range(10, 70);
      case (kind)
         0, 1: begin
            // fill run of 10 to 70 pushes; only runs past the depth hit full from empty
            repeat (len)
               queue_req($urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, pick_word());
         end
         2, 3: begin
            repeat (len)
               queue_req(mode_type'($urandom_range(MODE_PEEK_BACK, MODE_POP_FRONT)),
                         pick_word());
         end
         8: queue_req(MODE_CLEAR, pick_word());
         9: begin
            // overfill from the back, then overdrain from the front
            repeat (DEPTH + 3) queue_req(MODE_PUSH_BACK, pick_word());
            repeat (DEPTH + 3) queue_req(MODE_POP_FRONT, pick_word());
         end
         default: begin
            repeat (len) begin
               pick = $urandom_range(59);
               if (pick == 0)
                  queue_req(MODE_CLEAR, pick_word());
               else if (pick == 1)
                  queue_req(MODE_NONE, pick_word());
               else
                  queue_req(mode_type'($urandom_range(MODE_PEEK_BACK, MODE_PUSH_FRONT)),
                            pick_word());
            end
         end
      endcase
   endtask

   task automatic wait_idle();
      while (accepted_total != queued_total || expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      int target;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // refused reads on an empty queue, unused mode
      queue_req(MODE_PEEK_FRONT, 32'h1234_5678);
      queue_req(MODE_PEEK_BACK,  32'hFFFF_FFFF);
      queue_req(MODE_POP_FRONT,  32'h8000_0000);
      queue_req(MODE_POP_BACK,   32'h7FFF_FFFF);
      queue_req(MODE_NONE,       32'hDEAD_BEEF);
      // extremes pushed at both ends
      queue_req(MODE_PUSH_FRONT, 32'h7FFF_FFFF);
      queue_req(MODE_PUSH_BACK,  32'h8000_0000);
      queue_req(MODE_PUSH_FRONT, 32'h0000_0000);
      queue_req(MODE_PUSH_BACK,  32'hFFFF_FFFF);
      queue_req(MODE_PEEK_FRONT, 32'h5555_5555);
      queue_req(MODE_PEEK_BACK,  32'hAAAA_AAAA);
      queue_req(MODE_NONE,       32'h0000_0001);
      queue_req(MODE_POP_BACK,   32'h0);
      queue_req(MODE_POP_FRONT,  32'h0);
      queue_req(MODE_PEEK_FRONT, 32'h0);
      queue_req(MODE_CLEAR,      32'hFFFF_FFFF);
      queue_req(MODE_PEEK_BACK,  32'h0);
      queue_req(MODE_PUSH_BACK,  32'h5A5A_5A5A);
      queue_req(MODE_PUSH_FRONT, 32'hA5A5_A5A5);
      queue_req(MODE_POP_BACK,   32'h0);
      queue_req(MODE_POP_FRONT,  32'h0);
      queue_req(MODE_CLEAR,      32'h0);
      queue_req(MODE_POP_FRONT,  32'h0);

      add_segment(9);
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         send_idle_pct = send_pcts[phase];
         rsp_stall_pct = rsp_pcts[phase];
         target = counted_items + PHASE_ITEMS;
         while (counted_items < target)
            add_segment($urandom_range(9));
         // stall the receiver while a backlog is offered
         if (phase == 0)
            hold_trigger <= ~hold_trigger;
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_rsp_q.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      #3_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
design/dq_pkg.sv
design/dq_store.sv
design/dq_ctrl.sv
design/double_ended_queue.sv
tb/double_ended_queue_test.sv
